// File: rtl/slp_pkg.sv
// Shared types and constants for the sorted list kept in a fixed pool.
// Used by slp_pool_mem and sorted_list_in_fixed_pool; depends on nothing.
`default_nettype none
package slp_pkg;

	localparam int POOL_SIZE  = 64;
	localparam int IDX_W      = $clog2(POOL_SIZE);
	localparam int LINK_W     = $clog2(POOL_SIZE + 1);
	localparam int KEY_W      = 32;
	localparam int RANK_W     = 6;
	localparam int COUNT_W    = 7;
	localparam int MAX_LISTED = 64;

	// A link equal to the pool size names no entry.
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_DUMP   = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_LISTED    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_WR_SLOT,
		S_WR_PREV,
		S_RESP,
		S_DUMP
	} state_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic signed [KEY_W-1:0] key_in;
	} in_t;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] key_out;
		logic [RANK_W-1:0]       rank;
		logic [COUNT_W-1:0]      element_count;
		logic                    last;
	} out_t;

	typedef struct packed {
		logic [IDX_W-1:0]        rd_idx;
		logic                    key_we;
		logic                    link_we;
		logic [IDX_W-1:0]        wr_idx;
		logic signed [KEY_W-1:0] wr_key;
		logic [LINK_W-1:0]       wr_link;
	} mem_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [LINK_W-1:0]       link;
	} mem_rsp_t;

endpackage
`default_nettype wire

// File: rtl/slp_pool_mem.sv
// Pool storage: key memory and next-link memory, one read and one write port each.
// Depends on slp_pkg. Link entries not yet written read as their reset chain.
`default_nettype none
module slp_pool_mem (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slp_pkg::mem_req_t req,
	output slp_pkg::mem_rsp_t      rsp
);

	logic signed [slp_pkg::KEY_W-1:0] key_mem [slp_pkg::POOL_SIZE];
	logic [slp_pkg::LINK_W-1:0]       link_mem [slp_pkg::POOL_SIZE];
	logic [slp_pkg::POOL_SIZE-1:0]    link_vld_q;

	logic signed [slp_pkg::KEY_W-1:0] key_rd_q;
	logic [slp_pkg::LINK_W-1:0]       link_rd_q;
	logic [slp_pkg::IDX_W-1:0]        rd_idx_q;
	logic                             rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.wr_idx] <= req.wr_key;
		end
		if (req.link_we) begin
			link_mem[req.wr_idx] <= req.wr_link;
		end
		key_rd_q  <= key_mem[req.rd_idx];
		link_rd_q <= link_mem[req.rd_idx];
		rd_idx_q  <= req.rd_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			rd_vld_q <= link_vld_q[req.rd_idx];
			if (req.link_we) begin
				link_vld_q[req.wr_idx] <= 1'b1;
			end
		end
	end

	// An unwritten entry links to the next one; the top entry thus links to null.
	assign rsp.key  = key_rd_q;
	assign rsp.link = rd_vld_q ? link_rd_q
	                           : slp_pkg::LINK_W'(rd_idx_q) + slp_pkg::LINK_W'(1);

endmodule
`default_nettype wire

// File: rtl/sorted_list_in_fixed_pool.sv
// Sorted linked list in a fixed pool: control sequencer and output register.
// Depends on slp_pkg and slp_pool_mem.
//
// Usage: an input beat on in_data (opcode, key_in) is taken when in_valid and
// in_ready are both high; result beats leave on out_data under out_valid and
// out_ready. in_ready is high only while the sequencer is idle, so one
// command is processed at a time.
// An insert walks the list one entry per cycle through the pool memory, then
// splices the new entry in (S_WR_SLOT, then S_WR_PREV unless it becomes the head)
// before its single result beat. A duplicate or a full pool skips the splice.
// A dump emits one beat per listed key, one per cycle while out_ready stays
// high, with last set on the final beat; an empty list gives one beat.
// The walk rate is set by the registered read of the link memory,
// whose output feeds the next read address.
// When the receiver stalls, the result stays in the output register and a
// dump holds its place in the list, rereading the current entry.
// Reset empties the list and chains every entry on the free list at once;
// no clearing pass is needed.
`default_nettype none
module sorted_list_in_fixed_pool (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire slp_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output slp_pkg::out_t      out_data
);

	slp_pkg::state_t                  state_q, state_d;
	logic signed [slp_pkg::KEY_W-1:0] key_q, key_d;
	logic [slp_pkg::LINK_W-1:0]       cur_q, cur_d;
	logic [slp_pkg::LINK_W-1:0]       prev_q, prev_d;
	logic [slp_pkg::LINK_W-1:0]       head_q, head_d;
	logic [slp_pkg::LINK_W-1:0]       free_q, free_d;
	logic [slp_pkg::LINK_W-1:0]       slot_q, slot_d;
	logic [slp_pkg::COUNT_W-1:0]      count_q, count_d;
	logic [slp_pkg::RANK_W-1:0]       n_q, n_d;
	slp_pkg::status_t                 st_q, st_d;
	slp_pkg::out_t                    out_q, out_d;
	logic                             out_vld_q, out_vld_d;

	slp_pkg::mem_req_t req;
	slp_pkg::mem_rsp_t rsp;
	logic              out_free;
	logic              fin;

	slp_pool_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// A dump ends at the list tail or after the maximum number of beats.
	assign fin = (rsp.link == slp_pkg::NULL_LINK)
	          || (int'(n_q) + 1 >= slp_pkg::MAX_LISTED)
	          || (int'(n_q) + 1 >= slp_pkg::POOL_SIZE);

	always_comb begin
		state_d   = state_q;
		key_d     = key_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		head_d    = head_q;
		free_d    = free_q;
		slot_d    = slot_q;
		count_d   = count_q;
		n_d       = n_q;
		st_d      = st_q;
		out_d     = out_q;
		out_vld_d = out_vld_q && !out_ready;
		in_ready  = 1'b0;

		req         = '0;
		req.rd_idx  = cur_q[slp_pkg::IDX_W-1:0];
		req.wr_key  = key_q;

		case (state_q)
			slp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					key_d  = in_data.key_in;
					cur_d  = head_q;
					prev_d = slp_pkg::NULL_LINK;
					n_d    = '0;
					if (in_data.opcode == slp_pkg::OP_DUMP) begin
						if (head_q == slp_pkg::NULL_LINK) begin
							st_d    = slp_pkg::ST_EMPTY;
							state_d = slp_pkg::S_RESP;
						end else begin
							req.rd_idx = head_q[slp_pkg::IDX_W-1:0];
							state_d    = slp_pkg::S_DUMP;
						end
					end else if (free_q == slp_pkg::NULL_LINK) begin
						st_d    = slp_pkg::ST_FULL;
						state_d = slp_pkg::S_RESP;
					end else if (head_q == slp_pkg::NULL_LINK) begin
						req.rd_idx = free_q[slp_pkg::IDX_W-1:0];
						state_d    = slp_pkg::S_WR_SLOT;
					end else begin
						req.rd_idx = head_q[slp_pkg::IDX_W-1:0];
						state_d    = slp_pkg::S_WALK;
					end
				end
			end
			slp_pkg::S_WALK: begin
				// The read data belongs to cur_q, issued in the previous cycle.
				if (key_q > rsp.key) begin
					prev_d = cur_q;
					cur_d  = rsp.link;
					if (rsp.link == slp_pkg::NULL_LINK) begin
						req.rd_idx = free_q[slp_pkg::IDX_W-1:0];
						state_d    = slp_pkg::S_WR_SLOT;
					end else begin
						req.rd_idx = rsp.link[slp_pkg::IDX_W-1:0];
					end
				end else if (key_q == rsp.key) begin
					st_d    = slp_pkg::ST_DUPLICATE;
					state_d = slp_pkg::S_RESP;
				end else begin
					req.rd_idx = free_q[slp_pkg::IDX_W-1:0];
					state_d    = slp_pkg::S_WR_SLOT;
				end
			end
			slp_pkg::S_WR_SLOT: begin
				// The read data is the free-list link of the slot being taken.
				free_d      = rsp.link;
				slot_d      = free_q;
				req.key_we  = 1'b1;
				req.link_we = 1'b1;
				req.wr_idx  = free_q[slp_pkg::IDX_W-1:0];
				req.wr_link = cur_q;
				count_d     = count_q + slp_pkg::COUNT_W'(1);
				st_d        = slp_pkg::ST_INSERTED;
				if (prev_q == slp_pkg::NULL_LINK) begin
					head_d  = free_q;
					state_d = slp_pkg::S_RESP;
				end else begin
					state_d = slp_pkg::S_WR_PREV;
				end
			end
			slp_pkg::S_WR_PREV: begin
				req.link_we = 1'b1;
				req.wr_idx  = prev_q[slp_pkg::IDX_W-1:0];
				req.wr_link = slot_q;
				state_d     = slp_pkg::S_RESP;
			end
			slp_pkg::S_RESP: begin
				if (out_free) begin
					out_d.status        = st_q;
					out_d.key_out       = key_q;
					out_d.rank          = '0;
					out_d.element_count = count_q;
					out_d.last          = 1'b1;
					out_vld_d           = 1'b1;
					state_d             = slp_pkg::S_IDLE;
				end
			end
			slp_pkg::S_DUMP: begin
				if (out_free) begin
					out_d.status        = slp_pkg::ST_LISTED;
					out_d.key_out       = rsp.key;
					out_d.rank          = n_q;
					out_d.element_count = count_q;
					out_d.last          = fin;
					out_vld_d           = 1'b1;
					if (fin) begin
						state_d = slp_pkg::S_IDLE;
					end else begin
						cur_d      = rsp.link;
						n_d        = n_q + slp_pkg::RANK_W'(1);
						req.rd_idx = rsp.link[slp_pkg::IDX_W-1:0];
					end
				end
			end
			default: begin
				state_d = slp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= slp_pkg::S_IDLE;
			head_q    <= slp_pkg::NULL_LINK;
			free_q    <= '0;
			count_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			free_q    <= free_d;
			count_q   <= count_d;
			out_vld_q <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_d;
		cur_q  <= cur_d;
		prev_q <= prev_d;
		slot_q <= slot_d;
		n_q    <= n_d;
		st_q   <= st_d;
		out_q  <= out_d;
	end

endmodule
`default_nettype wire
